// ===== src/pkcs7_pad_unpad_stream_top_macros.svh =====
// Assertion macros used by the padding engine back end.
`ifndef PKCS7_PAD_UNPAD_STREAM_TOP_MACROS_SVH
`define PKCS7_PAD_UNPAD_STREAM_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PKCS_PAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PKCS_PAD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pkcs_pad_pkg.sv =====
// Shared types, constants and command encoding for the padding engine.
package pkcs_pad_pkg;

    localparam int DATA_W            = 8;
    localparam int BS_W              = 6;
    localparam int CNT_W             = 7;
    localparam int TDATA_OUT_W       = 16;
    localparam int CFG_ADDR_W        = 2;
    localparam int DEFAULT_MAX_BLOCK = 32;

    localparam logic [BS_W-1:0]   RESET_BLOCK_SIZE = 6'd16;
    localparam logic [DATA_W-1:0] PKCS5_MAX_PAD    = 8'h08;
    localparam logic [DATA_W-1:0] BYTE_MASK        = 8'hFF;

    localparam logic [CFG_ADDR_W-1:0] REG_DIRECTION  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAD_SCHEME = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PW    = 2;
    localparam int Q_CW    = 3;

    typedef enum logic [2:0] {
        K_PASS     = 3'd0,
        K_PASS_PAD = 3'd1,
        K_PASS_ERR = 3'd2,
        K_HOLD     = 3'd3,
        K_POP_HOLD = 3'd4,
        K_RELEASE  = 3'd5,
        K_ERR      = 3'd6,
        K_EMPTY    = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } t_cmd;

endpackage

// ===== src/pkcs_pad_front.sv =====
// Front end: configuration registers, item classification and length tracking.
module pkcs_pad_front #(
    parameter int MAX_BLOCK = pkcs_pad_pkg::DEFAULT_MAX_BLOCK
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [pkcs_pad_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pkcs_pad_pkg::BS_W-1:0]         i_cfg_wdata,
    input  logic                                  i_valid,
    input  logic [pkcs_pad_pkg::DATA_W-1:0]       i_byte,
    input  logic                                  i_last,
    output logic                                  o_ready,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output pkcs_pad_pkg::t_cmd                    o_cmd
);

    localparam int CW = pkcs_pad_pkg::CNT_W;
    localparam int DW = pkcs_pad_pkg::DATA_W;

    logic                            r_dir;
    logic                            r_scheme;
    logic [pkcs_pad_pkg::BS_W-1:0]   r_bsize;

    logic [CW-1:0] r_pos,  n_pos;
    logic [CW-1:0] r_hold, n_hold;
    logic [CW-1:0] r_run,  n_run;
    logic [DW-1:0] r_tail, n_tail;

    logic [pkcs_pad_pkg::BS_W-1:0] bs;
    logic [CW-1:0] bs_c, pos_inc, pos_nx, padn, hold_nx, run_inc, total, run_tot, d_cnt;
    logic          accept, pop_old, match, ok;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir    <= 1'b0;
            r_scheme <= 1'b0;
            r_bsize  <= pkcs_pad_pkg::RESET_BLOCK_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                pkcs_pad_pkg::REG_DIRECTION:  r_dir    <= i_cfg_wdata[0];
                pkcs_pad_pkg::REG_PAD_SCHEME: r_scheme <= i_cfg_wdata[0];
                pkcs_pad_pkg::REG_BLOCK_SIZE: r_bsize  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    always_comb begin
        // clamp block size: zero acts as one, oversize acts as the maximum
        if (r_bsize == '0)
            bs = pkcs_pad_pkg::BS_W'(1);
        else if (r_bsize > pkcs_pad_pkg::BS_W'(MAX_BLOCK))
            bs = pkcs_pad_pkg::BS_W'(MAX_BLOCK);
        else
            bs = r_bsize;
        bs_c    = CW'(bs);
        pos_inc = r_pos + CW'(1);
        pos_nx  = (pos_inc >= bs_c) ? '0 : pos_inc;
        padn    = bs_c - pos_nx;

        pop_old = (r_hold >= bs_c);
        hold_nx = pop_old ? r_hold : r_hold + CW'(1);
        match   = (r_hold != '0) && (r_tail == i_byte);
        run_inc = r_run + CW'(1);
        total   = r_hold + CW'(1);
        run_tot = match ? run_inc : CW'(1);

        ok = (pos_nx == '0) && (i_byte != '0) && (i_byte <= DW'(bs_c)) &&
             (i_byte <= DW'(total)) &&
             (!r_scheme || (i_byte <= pkcs_pad_pkg::PKCS5_MAX_PAD)) &&
             (DW'(run_tot) >= i_byte);
        d_cnt = total - CW'(i_byte & pkcs_pad_pkg::BYTE_MASK);

        n_pos  = r_pos;
        n_hold = r_hold;
        n_run  = r_run;
        n_tail = r_tail;
        o_cmd.kind  = pkcs_pad_pkg::K_PASS;
        o_cmd.data  = i_byte;
        o_cmd.count = '0;

        if (!r_dir) begin
            n_pos = pos_nx;
            if (i_last) begin
                n_pos  = '0;
                n_hold = '0;
                n_run  = '0;
                if (r_scheme && (padn > CW'(pkcs_pad_pkg::PKCS5_MAX_PAD))) begin
                    o_cmd.kind = pkcs_pad_pkg::K_PASS_ERR;
                end else begin
                    o_cmd.kind  = pkcs_pad_pkg::K_PASS_PAD;
                    o_cmd.count = padn;
                end
            end
        end else if (!i_last) begin
            // hold the byte; release the oldest one once a block is held
            o_cmd.kind = pop_old ? pkcs_pad_pkg::K_POP_HOLD : pkcs_pad_pkg::K_HOLD;
            n_pos  = pos_nx;
            n_hold = hold_nx;
            n_tail = i_byte;
            if (match)
                n_run = (run_inc > hold_nx) ? hold_nx : run_inc;
            else
                n_run = CW'(1);
        end else begin
            n_pos  = '0;
            n_hold = '0;
            n_run  = '0;
            if (!ok) begin
                o_cmd.kind = pkcs_pad_pkg::K_ERR;
            end else if (d_cnt == '0) begin
                o_cmd.kind = pkcs_pad_pkg::K_EMPTY;
            end else begin
                o_cmd.kind  = pkcs_pad_pkg::K_RELEASE;
                o_cmd.count = d_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_hold <= '0;
            r_run  <= '0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_hold <= n_hold;
            r_run  <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_tail <= n_tail;
    end

endmodule

// ===== src/pkcs_pad_cmdq.sv =====
// Short command queue between the front and back ends.
module pkcs_pad_cmdq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pkcs_pad_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output pkcs_pad_pkg::t_cmd o_cmd
);

    pkcs_pad_pkg::t_cmd r_q [pkcs_pad_pkg::Q_DEPTH];
    logic [pkcs_pad_pkg::Q_PW-1:0] r_wp, r_rp;
    logic [pkcs_pad_pkg::Q_CW-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == pkcs_pad_pkg::Q_CW'(pkcs_pad_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wp <= r_wp + pkcs_pad_pkg::Q_PW'(1);
            if (do_pop)
                r_rp <= r_rp + pkcs_pad_pkg::Q_PW'(1);
            if (do_push && !do_pop)
                r_cnt <= r_cnt + pkcs_pad_pkg::Q_CW'(1);
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - pkcs_pad_pkg::Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_q[r_wp] <= i_cmd;
    end

endmodule

// ===== src/pkcs_pad_back.sv =====
// Back end: hold buffer, pad burst and release sequencer, output register.
`include "pkcs7_pad_unpad_stream_top_macros.svh"

module pkcs_pad_back #(
    parameter int MAX_BLOCK = pkcs_pad_pkg::DEFAULT_MAX_BLOCK
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cmd_valid,
    input  pkcs_pad_pkg::t_cmd                      i_cmd,
    output logic                                    o_cmd_pop,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    output logic [pkcs_pad_pkg::TDATA_OUT_W-1:0]    o_m_tdata,
    output logic                                    o_m_tlast,
    output logic                                    o_m_tuser
);

    localparam int PW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int CW = pkcs_pad_pkg::CNT_W;
    localparam int DW = pkcs_pad_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_REL  = 4'b0010,
        ST_PAD  = 4'b0100,
        ST_ERR  = 4'b1000
    } t_bstate;

    t_bstate       r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [DW-1:0] r_padv,  n_padv;
    logic          r_rel_end, n_rel_end;
    logic [PW-1:0] r_head,  n_head;
    logic [PW-1:0] r_tail,  n_tail;

    logic [DW-1:0] mem [MAX_BLOCK];
    logic [DW-1:0] r_rd;
    logic          rd_en, wr_en;

    logic          r_ovalid, n_ovalid;
    logic [DW-1:0] r_obyte,  n_obyte;
    logic          r_obvalid, n_obvalid;
    logic          r_olast,  n_olast;
    logic          r_obad,   n_obad;
    logic          advance;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(MAX_BLOCK - 1)) ? '0 : p + PW'(1);
    endfunction

    assign advance = !r_ovalid || i_m_tready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_padv    = r_padv;
        n_rel_end = r_rel_end;
        n_head    = r_head;
        n_tail    = r_tail;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        o_cmd_pop = 1'b0;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_obyte   = r_obyte;
        n_obvalid = r_obvalid;
        n_olast   = r_olast;
        n_obad    = r_obad;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        pkcs_pad_pkg::K_HOLD: begin
                            wr_en     = 1'b1;
                            n_tail    = ptr_inc(r_tail);
                            o_cmd_pop = 1'b1;
                        end
                        pkcs_pad_pkg::K_POP_HOLD: begin
                            // read the oldest byte before the new one lands
                            rd_en     = 1'b1;
                            wr_en     = 1'b1;
                            n_head    = ptr_inc(r_head);
                            n_tail    = ptr_inc(r_tail);
                            n_cnt     = CW'(1);
                            n_rel_end = 1'b0;
                            n_state   = ST_REL;
                            o_cmd_pop = 1'b1;
                        end
                        pkcs_pad_pkg::K_RELEASE: begin
                            rd_en     = 1'b1;
                            n_head    = ptr_inc(r_head);
                            n_cnt     = i_cmd.count;
                            n_rel_end = 1'b1;
                            n_state   = ST_REL;
                            o_cmd_pop = 1'b1;
                        end
                        pkcs_pad_pkg::K_PASS,
                        pkcs_pad_pkg::K_PASS_PAD,
                        pkcs_pad_pkg::K_PASS_ERR: begin
                            if (advance) begin
                                o_cmd_pop = 1'b1;
                                n_ovalid  = 1'b1;
                                n_obyte   = i_cmd.data;
                                n_obvalid = 1'b1;
                                n_olast   = 1'b0;
                                n_obad    = 1'b0;
                                if (i_cmd.kind == pkcs_pad_pkg::K_PASS_PAD) begin
                                    n_cnt   = i_cmd.count;
                                    n_padv  = DW'(i_cmd.count);
                                    n_state = ST_PAD;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else if (i_cmd.kind == pkcs_pad_pkg::K_PASS_ERR) begin
                                    n_state = ST_ERR;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end
                            end
                        end
                        pkcs_pad_pkg::K_ERR,
                        pkcs_pad_pkg::K_EMPTY: begin
                            if (advance) begin
                                o_cmd_pop = 1'b1;
                                n_ovalid  = 1'b1;
                                n_obyte   = '0;
                                n_obvalid = 1'b0;
                                n_olast   = 1'b1;
                                n_obad    = (i_cmd.kind == pkcs_pad_pkg::K_ERR);
                                n_head    = '0;
                                n_tail    = '0;
                            end
                        end
                    endcase
                end
            end
            ST_REL: begin
                if (advance) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = r_rd;
                    n_obvalid = 1'b1;
                    n_olast   = r_rel_end && (r_cnt == CW'(1));
                    n_obad    = 1'b0;
                    if (r_cnt == CW'(1)) begin
                        n_state = ST_IDLE;
                        if (r_rel_end) begin
                            n_head = '0;
                            n_tail = '0;
                        end
                    end else begin
                        // fetch the next held byte while this one goes out
                        rd_en  = 1'b1;
                        n_head = ptr_inc(r_head);
                        n_cnt  = r_cnt - CW'(1);
                    end
                end
            end
            ST_PAD: begin
                if (advance) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = r_padv;
                    n_obvalid = 1'b1;
                    n_olast   = (r_cnt == CW'(1));
                    n_obad    = 1'b0;
                    n_cnt     = r_cnt - CW'(1);
                    if (r_cnt == CW'(1))
                        n_state = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (advance) begin
                    n_ovalid  = 1'b1;
                    n_obyte   = '0;
                    n_obvalid = 1'b0;
                    n_olast   = 1'b1;
                    n_obad    = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_rel_end <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rel_end <= n_rel_end;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_padv    <= n_padv;
        r_obyte   <= n_obyte;
        r_obvalid <= n_obvalid;
        r_olast   <= n_olast;
        r_obad    <= n_obad;
    end

    // hold buffer: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en)
            mem[r_tail] <= i_cmd.data;
        if (rd_en)
            r_rd <= mem[r_head];
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(pkcs_pad_pkg::TDATA_OUT_W - DW - 1){1'b0}}, r_obvalid, r_obyte};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_obad;

    `PKCS_PAD_ASSERT_IMP(a_pad_cnt_live, i_clk, i_rst_n, (r_state == ST_PAD), (r_cnt != '0), "pad burst with zero count")
    `PKCS_PAD_ASSERT_IMP(a_rel_cnt_live, i_clk, i_rst_n, (r_state == ST_REL), (r_cnt != '0), "release with zero count")
    `PKCS_PAD_ASSERT_IMP(a_err_shape, i_clk, i_rst_n, (r_ovalid && r_obad), (r_olast && !r_obvalid && (r_obyte == '0)), "error result malformed")
    `PKCS_PAD_ASSERT_NXT(a_pop_only_idle, i_clk, i_rst_n, (o_cmd_pop && (i_cmd.kind == pkcs_pad_pkg::K_HOLD)), (r_state == ST_IDLE), "hold command left idle state")

endmodule

// ===== src/pkcs7_pad_unpad_stream_top.sv =====
// Top level of the PKCS#7 / PKCS#5 byte-stream padding engine.
// Usage:
//   Input stream carries one message byte per item (tdata[7:0]); tlast marks the last
//   byte of a message. Output stream carries one result per item: tdata[7:0] byte,
//   tdata[8] byte-valid flag; tlast marks the final result, tuser flags bad padding.
//   Configuration registers (direction, pad scheme, block size) are written through
//   the plain write port between messages; a write takes effect on the next item.
// Flow:
//   A front end classifies each byte combinationally and posts one command to a
//   four-entry queue; the back end runs it, and results leave through the output
//   register. Pad direction moves one byte a cycle while the output is not stalled,
//   then sends the pad bytes after the last item. Unpad direction holds each byte
//   while the hold buffer fills; once full, each byte releases the oldest by a registered
//   read before the next command runs, and the final release sends the remaining bytes.
// Reset (synchronous, active low) restores the register defaults, empties the queue
//   and the hold buffer pointers and drops any pending result.
// Stall: when the receiver deasserts tready the output register holds its result;
//   the back end stops at its next result and input tready drops when the queue is full.
module pkcs7_pad_unpad_stream_top #(
    parameter int MAX_BLOCK = pkcs_pad_pkg::DEFAULT_MAX_BLOCK
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [pkcs_pad_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [pkcs_pad_pkg::BS_W-1:0]         i_cfg_wdata,
    // input stream
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [pkcs_pad_pkg::DATA_W-1:0]       i_s_tdata,   // [7:0] data_byte
    input  logic                                  i_s_tlast,   // last_byte
    // output stream
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [pkcs_pad_pkg::TDATA_OUT_W-1:0]  o_m_tdata,   // [7:0] out_byte, [8] out_valid
    output logic                                  o_m_tlast,   // out_last
    output logic                                  o_m_tuser    // bad_padding
);

    pkcs_pad_pkg::t_cmd front_cmd;
    pkcs_pad_pkg::t_cmd q_cmd;
    logic               front_push;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;

    // classify each byte and track block position and held length
    pkcs_pad_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_ready     (o_s_tready),
        .i_q_full    (q_full),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    // decouple classification from the multi-cycle bursts
    pkcs_pad_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // run commands: hold, release, pad bursts, error and empty results
    pkcs_pad_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
